// ===== rtl/gwrm_pkg.sv =====
// Package for the Geiger window rate meter: item types and fixed constants.
// Used by gwrm_divider and geiger_window_rate_meter.
package gwrm_pkg;

  typedef struct packed {
    logic [3:0] rad_pulses;
    logic [3:0] noise_pulses;
  } gwrm_in_t;

  typedef struct packed {
    logic        processed;
    logic        radiation_event;
    logic        noise_event;
    logic [31:0] window_count;
    logic [23:0] integration_ms;
    logic [31:0] cpm_x16;
  } gwrm_out_t;

  localparam logic [0:0]  CFG_PERIOD = 1'b0;
  localparam logic [0:0]  CFG_UNIT   = 1'b1;
  localparam logic [19:0] CPM_SCALE  = 20'd960000;
  localparam logic [23:0] INTEG_MAX  = 24'hFFFFFF;
  localparam logic [15:0] CNT16_MAX  = 16'hFFFF;

endpackage

// ===== rtl/gwrm_divider.sv =====
// Restoring divider, one quotient bit per cycle: 52-bit dividend by 24-bit divisor.
// Depends on gwrm_pkg (package import only).
module gwrm_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [51:0] dividend,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [51:0] quotient
);
  import gwrm_pkg::*;

  logic [51:0] quo;
  logic [24:0] rem;
  logic [23:0] dvs;
  logic [5:0]  cnt;
  logic [24:0] shifted;
  logic [25:0] diff;

  assign shifted  = {rem[23:0], quo[51]};
  assign diff     = {1'b0, shifted} - {2'b0, dvs};
  assign quotient = quo;

  // Shift one dividend bit in and subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= 6'd52;
      end else if (busy) begin
        if (!diff[25]) begin
          rem <= diff[24:0];
          quo <= {quo[50:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[50:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("divider count ran out while busy");
endmodule

// ===== rtl/geiger_window_rate_meter.sv =====
// Geiger counter sliding-window rate meter, top level.
// Path from accept to result: an item due for processing reads and updates its current bucket,
//   and the oldest bucket too when the ring shifts; every item then passes integration and the
// divide wait, skipped when integration is zero. The divider is the 52-step rate divider; input
// stalls while an item is in flight or its result waits. Reset: rst synchronous, clears control and
// counters, then a clearing pass zeroes the bucket memory, no item taken.
module geiger_window_rate_meter #(
  parameter int BUCKET_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  gwrm_pkg::gwrm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gwrm_pkg::gwrm_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [9:0]          cfg_data
);
  import gwrm_pkg::*;

  localparam int IW = $clog2(BUCKET_COUNT);
  localparam int FW = $clog2(BUCKET_COUNT) + 1;
  localparam logic [FW-1:0] FILL_MAX = FW'(BUCKET_COUNT - 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(BUCKET_COUNT - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_CUR, S_WR_CUR, S_RD_OLD, S_WR_OLD, S_INTEG, S_DIV, S_WAIT, S_OUT
  } state_t;

  state_t      state;
  logic [15:0] mem [BUCKET_COUNT];
  logic [15:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic        wr_en;
  logic [IW-1:0] wr_addr;
  logic [15:0] wr_data;

  logic [9:0]  period;
  logic [5:0]  unit_s;
  logic [31:0] total;
  logic [IW-1:0] idx;
  logic [FW-1:0] filled;
  logic [31:0] ms_clock, last_proc, last_shift;
  logic [31:0] shift_age;
  logic [15:0] pend_rad, pend_noise;
  logic [15:0] rad, noise;
  logic        proc_flag;
  logic [IW-1:0] clr_idx;
  logic [15:0] unit_ms;
  logic [16:0] sum17;
  logic [15:0] sat_sum;
  logic [41:0] integ_full;
  logic [23:0] integ;
  logic        div_start, div_busy, div_done;
  logic [51:0] quo;
  logic [16:0] prad_sum, pnoise_sum;

  assign unit_ms = 16'(unit_s) * 16'd1000;
  assign sum17   = {1'b0, rd_data} + {1'b0, rad};
  assign sat_sum = sum17[16] ? CNT16_MAX : sum17[15:0];
  assign prad_sum   = {1'b0, pend_rad} + 17'(in_data.rad_pulses);
  assign pnoise_sum = {1'b0, pend_noise} + 17'(in_data.noise_pulses);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Bucket memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = sat_sum;
    rd_addr = idx;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1; wr_addr = clr_idx; wr_data = '0;
      end
      S_WR_CUR: wr_en = (noise == 16'd0);
      S_WR_OLD: begin
        wr_en = 1'b1; wr_data = '0;
      end
      default: ;
    endcase
  end

  gwrm_divider u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend({20'd0, total} * {32'd0, CPM_SCALE}),
    .divisor(integ), .busy(div_busy), .done(div_done), .quotient(quo)
  );

  // Sequence one item through the memory and the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_idx <= '0; period <= 10'd160; unit_s <= 6'd6;
      total <= '0; idx <= '0; filled <= '0; ms_clock <= '0; last_proc <= '0;
      last_shift <= '0; pend_rad <= '0; pend_noise <= '0; out_valid <= 1'b0;
      div_start <= 1'b0; proc_flag <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_PERIOD) period <= cfg_data;
        else unit_s <= cfg_data[5:0];
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == IDX_LAST) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          ms_clock <= ms_clock + 32'd1;
          if (ms_clock + 32'd1 - last_proc >= 32'(period)) begin
            rad <= prad_sum[16] ? CNT16_MAX : prad_sum[15:0];
            noise <= pnoise_sum[16] ? CNT16_MAX : pnoise_sum[15:0];
            pend_rad <= '0; pend_noise <= '0;
            proc_flag <= 1'b1; state <= S_RD_CUR;
          end else begin
            pend_rad <= prad_sum[16] ? CNT16_MAX : prad_sum[15:0];
            pend_noise <= pnoise_sum[16] ? CNT16_MAX : pnoise_sum[15:0];
            proc_flag <= 1'b0; state <= S_INTEG;
          end
        end
        S_RD_CUR: state <= S_WR_CUR;
        S_WR_CUR: begin
          if (noise == 16'd0) total <= total + 32'(sat_sum) - 32'(rd_data);
          last_proc <= ms_clock;
          if (ms_clock - last_shift >= 32'(unit_ms)) begin
            last_shift <= last_shift + 32'(unit_ms);
            idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
            if (filled < FILL_MAX) filled <= filled + 1'b1;
            state <= S_RD_OLD;
          end else state <= S_INTEG;
        end
        S_RD_OLD: state <= S_WR_OLD;
        S_WR_OLD: begin
          total <= total - 32'(rd_data);
          state <= S_INTEG;
        end
        S_INTEG: begin
          integ <= (integ_full > 42'(INTEG_MAX)) ? INTEG_MAX : integ_full[23:0];
          state <= S_DIV;
        end
        S_DIV: begin
          if (integ == 24'd0) state <= S_OUT;
          else begin
            div_start <= 1'b1; state <= S_WAIT;
          end
        end
        S_WAIT: if (div_done) state <= S_OUT;
        // Hold the new result until the previous one has left
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          out_data.processed <= proc_flag;
          out_data.radiation_event <= proc_flag && (rad != 16'd0);
          out_data.noise_event <= proc_flag && (noise != 16'd0);
          out_data.window_count <= total;
          out_data.integration_ms <= integ;
          out_data.cpm_x16 <= (integ == 24'd0) ? 32'd0 :
                              (|quo[51:32]) ? 32'hFFFFFFFF : quo[31:0];
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
    end
  end

  assign shift_age  = last_proc - last_shift;
  assign integ_full = 42'(filled) * 42'(unit_ms) + 42'(shift_age);

  assert property (@(posedge clk) disable iff (rst)
                   out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");
  assert property (@(posedge clk) disable iff (rst)
                   state == S_WAIT |-> div_start || div_busy || div_done)
    else $error("waiting on idle divider");
  assert property (@(posedge clk) disable iff (rst) filled <= FILL_MAX)
    else $error("filled count out of range");
endmodule
